// ===== hw/rtl/tcfo_pkg.sv =====
// Package for the two-class FIFO: request and status codes, class indexes
// and the result record. No dependencies.
package tcfo_pkg;

  localparam int unsigned STAMP_W = 16;
  localparam int unsigned ID_W    = 32;

  // class index, also the out_kind code
  localparam int unsigned CLS_CAT = 0;
  localparam int unsigned CLS_DOG = 1;

  typedef enum logic [1:0] {
    FUNC_ENQ     = 2'd0,
    FUNC_DEQ_ANY = 2'd1,
    FUNC_DEQ_DOG = 2'd2,
    FUNC_DEQ_CAT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic             kind;
    logic [ID_W-1:0]  name_id;
  } res_t;

endpackage

// ===== hw/rtl/two_class_fifo_oldest_any.sv =====
// Two-class FIFO (cat / dog) with dequeue-oldest, top level.
// Depends on tcfo_pkg.
//
// One request is taken per clock cycle while the skid register is empty.
// Its result is registered, in the output register or, while that one holds
// a waiting result, in the skid register. Each class keeps its
// entries in a synchronous-read memory; the head entry of each class is
// prefetched into the memory's read register in the cycle that moves the
// head, with a bypass when the entry being written is the new head, so a
// request only needs the two head registers, a 16-bit stamp subtract and
// a select. A two-deep result buffer (output register plus skid register)
// keeps the slave side open while one result waits on the master side.
module two_class_fifo_oldest_any #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned NAME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] name_id
  input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] out_name_id
  output logic [2:0]  m_axis_tuser    // [0] out_kind, [2:1] status
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IDW = tcfo_pkg::ID_W;
  localparam int unsigned SW  = tcfo_pkg::STAMP_W;

  typedef struct packed {
    logic [NAME_BITS-1:0] name;
    logic [SW-1:0]        stamp;
  } entry_t;

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  logic            acc;
  tcfo_pkg::func_e func;
  logic            kind_in;
  entry_t          wentry;

  assign acc           = s_axis_tvalid & s_axis_tready;
  assign func          = tcfo_pkg::func_e'(s_axis_tuser[1:0]);
  assign kind_in       = s_axis_tuser[2];

  // ---------------------------------------------------------------------
  // Per-class pointers, counts, storage and prefetched head
  // ---------------------------------------------------------------------
  logic [AW-1:0] head_q  [2];
  logic [AW-1:0] head_d  [2];
  logic [AW-1:0] tail_q  [2];
  logic [AW-1:0] tail_d  [2];
  logic [CW-1:0] count_q [2];
  logic [CW-1:0] count_d [2];
  entry_t        hd_q    [2];   // registered read data = current head entry
  entry_t        mem_q   [2][DEPTH];
  logic [1:0]    push;
  logic [1:0]    pop;
  logic [1:0]    nonempty;
  logic [SW-1:0] stamp_q;
  logic [SW-1:0] stamp_d;

  // incoming handle, zero-extended or truncated to the stored width
  always_comb begin
    wentry.name = '0;
    for (int b = 0; b < int'(NAME_BITS) && b < int'(IDW); b++) begin
      wentry.name[b] = s_axis_tdata[b];
    end
    wentry.stamp = stamp_q;
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      nonempty[c] = (count_q[c] != '0);
    end
  end

  // Request decode: which class pushes, which pops, and the status.
  logic          take_vld;
  logic          take_dog;
  logic [SW-1:0] stamp_diff;
  logic          enq_full;

  assign stamp_diff = hd_q[tcfo_pkg::CLS_CAT].stamp - hd_q[tcfo_pkg::CLS_DOG].stamp;
  assign enq_full   = (count_q[kind_in] == CW'(DEPTH));

  always_comb begin
    take_vld = 1'b0;
    take_dog = 1'b0;
    unique case (func)
      tcfo_pkg::FUNC_ENQ: begin
        take_vld = 1'b0;
      end
      tcfo_pkg::FUNC_DEQ_ANY: begin
        if (nonempty[tcfo_pkg::CLS_CAT] && nonempty[tcfo_pkg::CLS_DOG]) begin
          // cat wins on a tie or when its stamp is behind (wrap-safe)
          take_vld = 1'b1;
          take_dog = ~((stamp_diff == '0) | stamp_diff[SW-1]);
        end else begin
          take_vld = nonempty[tcfo_pkg::CLS_CAT] | nonempty[tcfo_pkg::CLS_DOG];
          take_dog = ~nonempty[tcfo_pkg::CLS_CAT];
        end
      end
      tcfo_pkg::FUNC_DEQ_DOG: begin
        take_vld = nonempty[tcfo_pkg::CLS_DOG];
        take_dog = 1'b1;
      end
      tcfo_pkg::FUNC_DEQ_CAT: begin
        take_vld = nonempty[tcfo_pkg::CLS_CAT];
        take_dog = 1'b0;
      end
      default: begin
        take_vld = 1'b0;
      end
    endcase
  end

  always_comb begin
    push = '0;
    pop  = '0;
    if (acc && (func == tcfo_pkg::FUNC_ENQ) && !enq_full) begin
      push[kind_in] = 1'b1;
    end
    if (acc && take_vld) begin
      pop[take_dog] = 1'b1;
    end
    stamp_d = (|push) ? stamp_q + SW'(1) : stamp_q;
    for (int c = 0; c < 2; c++) begin
      head_d[c]  = head_q[c];
      tail_d[c]  = tail_q[c];
      count_d[c] = count_q[c];
      if (pop[c]) begin
        head_d[c]  = (head_q[c] == AW'(DEPTH - 1)) ? '0 : head_q[c] + AW'(1);
        count_d[c] = count_q[c] - CW'(1);
      end
      if (push[c]) begin
        tail_d[c]  = (tail_q[c] == AW'(DEPTH - 1)) ? '0 : tail_q[c] + AW'(1);
        count_d[c] = count_q[c] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
      end
      stamp_q <= '0;
    end else begin
      for (int c = 0; c < 2; c++) begin
        head_q[c]  <= head_d[c];
        tail_q[c]  <= tail_d[c];
        count_q[c] <= count_d[c];
      end
      stamp_q <= stamp_d;
    end
  end

  // Storage: one write at the tail, one registered read at the next head.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      if (push[c]) begin
        mem_q[c][tail_q[c]] <= wentry;
      end
      if (push[c] && (tail_q[c] == head_d[c])) begin
        hd_q[c] <= wentry;
      end else begin
        hd_q[c] <= mem_q[c][head_d[c]];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result formation
  // ---------------------------------------------------------------------
  tcfo_pkg::res_t res;

  always_comb begin
    res.name_id = '0;
    res.kind    = 1'b0;
    res.status  = tcfo_pkg::ST_OK;
    if (func == tcfo_pkg::FUNC_ENQ) begin
      res.status = enq_full ? tcfo_pkg::ST_FULL : tcfo_pkg::ST_OK;
    end else if (take_vld) begin
      res.kind = take_dog;
      for (int b = 0; b < int'(NAME_BITS) && b < int'(IDW); b++) begin
        res.name_id[b] = hd_q[take_dog].name[b];
      end
    end else begin
      res.status = tcfo_pkg::ST_EMPTY;
    end
  end

  // ---------------------------------------------------------------------
  // Two-deep result buffer: output register plus skid register
  // ---------------------------------------------------------------------
  logic           out_vld_q, out_vld_d;
  logic           skid_vld_q, skid_vld_d;
  tcfo_pkg::res_t out_q, out_d;
  tcfo_pkg::res_t skid_q, skid_d;
  logic           out_xfer;

  assign s_axis_tready = ~skid_vld_q;
  assign out_xfer      = out_vld_q & m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (out_xfer) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = acc;
      end
    end else if (!out_vld_q) begin
      out_d     = res;
      out_vld_d = acc;
    end else if (acc) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.name_id;
  assign m_axis_tuser  = {out_q.status, out_q.kind};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cat_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[tcfo_pkg::CLS_CAT] <= CW'(DEPTH))
    else $error("cat count above depth");

  a_dog_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[tcfo_pkg::CLS_DOG] <= CW'(DEPTH))
    else $error("dog count above depth");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a result while output register is empty");

  a_stamp_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|push) |=> (stamp_q == $past(stamp_q) + SW'(1)))
    else $error("arrival stamp did not advance on a stored enqueue");

  a_one_class_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((|push) && (|pop)))
    else $error("push and pop in the same cycle");

endmodule

// ===== tb/two_class_fifo_oldest_any_checker.sv =====
// Checker for the two-class FIFO: tracks both class queues and the arrival
// stamp, predicts each result and compares it with the master side.
// Depends on tcfo_pkg.
module two_class_fifo_oldest_any_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_ready_i,
  input  logic [tcfo_pkg::ID_W-1:0] req_data_i,   // [31:0] name_id
  input  logic [2:0]                req_user_i,   // [1:0] func, [2] kind
  input  logic                      res_valid_i,
  input  logic                      res_ready_i,
  input  logic [tcfo_pkg::ID_W-1:0] res_data_i,   // [31:0] out_name_id
  input  logic [2:0]                res_user_i,   // [0] out_kind, [2:1] status
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAKE_NONE = -1;

  typedef struct packed {
    logic [tcfo_pkg::ID_W-1:0]    name_id;
    logic [tcfo_pkg::STAMP_W-1:0] stamp;
  } slot_t;

  slot_t                        cat_fifo[$];
  slot_t                        dog_fifo[$];
  logic [tcfo_pkg::STAMP_W-1:0] stamp_ctr;
  tcfo_pkg::res_t               expected_q[$];
  int unsigned                  fail_cnt = 0;

  // One request against the tracked queues; returns the result it yields.
  function automatic tcfo_pkg::res_t shelter_result(tcfo_pkg::func_e f, logic k,
                                                    logic [tcfo_pkg::ID_W-1:0] n);
    tcfo_pkg::res_t               r;
    slot_t                        s;
    logic [tcfo_pkg::STAMP_W-1:0] diff;
    int                           take;
    r    = '{status: tcfo_pkg::ST_OK, kind: 1'b0, name_id: '0};
    take = TAKE_NONE;
    case (f)
      tcfo_pkg::FUNC_ENQ: begin
        // full queue: nothing stored, stamp holds
        if (k == 1'(tcfo_pkg::CLS_DOG)) begin
          if (dog_fifo.size() >= DEPTH) begin
            r.status = tcfo_pkg::ST_FULL;
          end else begin
            dog_fifo.push_back('{n, stamp_ctr});
            stamp_ctr++;
          end
        end else begin
          if (cat_fifo.size() >= DEPTH) begin
            r.status = tcfo_pkg::ST_FULL;
          end else begin
            cat_fifo.push_back('{n, stamp_ctr});
            stamp_ctr++;
          end
        end
      end
      tcfo_pkg::FUNC_DEQ_ANY: begin
        if (cat_fifo.size() != 0 && dog_fifo.size() != 0) begin
          // wrap-safe age compare; a tie goes to cat
          diff = cat_fifo[0].stamp - dog_fifo[0].stamp;
          take = (diff == '0 || diff[tcfo_pkg::STAMP_W-1]) ?
                 int'(tcfo_pkg::CLS_CAT) : int'(tcfo_pkg::CLS_DOG);
        end else if (cat_fifo.size() != 0) begin
          take = int'(tcfo_pkg::CLS_CAT);
        end else if (dog_fifo.size() != 0) begin
          take = int'(tcfo_pkg::CLS_DOG);
        end else begin
          r.status = tcfo_pkg::ST_EMPTY;
        end
      end
      tcfo_pkg::FUNC_DEQ_DOG: begin
        if (dog_fifo.size() != 0) take = int'(tcfo_pkg::CLS_DOG);
        else r.status = tcfo_pkg::ST_EMPTY;
      end
      default: begin
        if (cat_fifo.size() != 0) take = int'(tcfo_pkg::CLS_CAT);
        else r.status = tcfo_pkg::ST_EMPTY;
      end
    endcase
    if (take == int'(tcfo_pkg::CLS_CAT)) begin
      s         = cat_fifo.pop_front();
      r.name_id = s.name_id;
      r.kind    = 1'(tcfo_pkg::CLS_CAT);
    end else if (take == int'(tcfo_pkg::CLS_DOG)) begin
      s         = dog_fifo.pop_front();
      r.name_id = s.name_id;
      r.kind    = 1'(tcfo_pkg::CLS_DOG);
    end
    return r;
  endfunction

  // Result check runs before the request update: a result can never belong
  // to a request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tcfo_pkg::res_t exp_r;
    if (!rst_ni) begin
      cat_fifo.delete();
      dog_fifo.delete();
      expected_q.delete();
      stamp_ctr = '0;
      pending_o    <= 0;
      fail_count_o <= fail_cnt;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: out_name_id %h", res_data_i);
          fail_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (res_data_i !== exp_r.name_id) begin
            $error("out_name_id: expected %h, got %h", exp_r.name_id, res_data_i);
            fail_cnt++;
          end
          if (res_user_i[0] !== exp_r.kind) begin
            $error("out_kind: expected %0d, got %0d", exp_r.kind, res_user_i[0]);
            fail_cnt++;
          end
          if (res_user_i[2:1] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, res_user_i[2:1]);
            fail_cnt++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_q.push_back(shelter_result(tcfo_pkg::func_e'(req_user_i[1:0]),
                                            req_user_i[2], req_data_i));
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

// ===== tb/two_class_fifo_oldest_any_tb.sv =====
// Top of the two-class FIFO testbench: clock, reset, request stimulus and
// result back-pressure, plus the verdict. Depends on tcfo_pkg, the block
// and two_class_fifo_oldest_any_checker.
module two_class_fifo_oldest_any_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CYCLE_CAP   = 2_000_000;
  localparam int unsigned IDLE_PCT    = 13;
  // pairs of enqueue / dequeue-any with entries of both classes in flight
  localparam int unsigned CHURN_PAIRS = 60;
  localparam int unsigned STEADY_PAIRS = 40;

  logic                      clk_i   = 1'b0;
  logic                      rst_ni  = 1'b0;
  logic                      s_valid = 1'b0;
  logic                      s_ready;
  logic [tcfo_pkg::ID_W-1:0] s_data  = '0;
  logic [2:0]                s_user  = '0;
  logic                      m_valid;
  logic                      m_ready = 1'b0;
  logic [tcfo_pkg::ID_W-1:0] m_data;
  logic [2:0]                m_user;
  logic                      steady  = 1'b0;   // no idling on either side while set
  int unsigned               fail_count;
  int unsigned               pending;
  int unsigned               cycle_cnt;

  always #1 clk_i = ~clk_i;

  two_class_fifo_oldest_any #(
    .DEPTH     (DEPTH),
    .NAME_BITS (tcfo_pkg::ID_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  two_class_fifo_oldest_any_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_valid),
    .req_ready_i  (s_ready),
    .req_data_i   (s_data),
    .req_user_i   (s_user),
    .res_valid_i  (m_valid),
    .res_ready_i  (m_ready),
    .res_data_i   (m_data),
    .res_user_i   (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver side: random stalls, none while steady is set.
  always @(posedge clk_i) begin
    m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Timeout guard.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("two_class_fifo_oldest_any_tb failed");
    $finish;
  end

  // One request transfer, with optional idle cycles ahead of it. Returns at
  // the edge where the transfer happens.
  task automatic push_request(tcfo_pkg::func_e f, logic k, logic [tcfo_pkg::ID_W-1:0] n);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= n;
    s_user  <= {k, f};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // Random traffic in fill and drain spells, so both queues reach full and
  // empty. A fill spell mostly enqueues into one favored class.
  task automatic run_mixed(int unsigned n_items);
    logic fill;
    logic favor;
    logic k;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        fill  = 1'($urandom_range(1));
        favor = 1'($urandom_range(1));
      end
      if ($urandom_range(99) < (fill ? 80 : 20)) begin
        k = ($urandom_range(99) < 85) ? favor : ~favor;
        push_request(tcfo_pkg::FUNC_ENQ, k, $urandom());
      end else begin
        push_request(tcfo_pkg::func_e'($urandom_range(3, 1)), 1'($urandom_range(1)),
                     $urandom());
      end
    end
  endtask

  task automatic hold_until_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stim
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pops on every dequeue kind; kind and name are don't-cares.
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b0, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_DOG, 1'b1, 32'hFFFF_FFFF);
    push_request(tcfo_pkg::FUNC_DEQ_CAT, 1'b0, 32'hFFFF_FFFF);
    // Interleaved arrivals; dequeue-any must follow arrival order.
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_CAT), 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_DOG), 32'hFFFF_FFFF);
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_DOG), 32'hA5A5_A5A5);
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_CAT), 32'h5A5A_5A5A);
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b1, 32'h1234_5678);
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b0, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b1, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b0, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b0, 32'h0000_0000);
    // Typed pops while only one class holds entries, on both that class and the empty one.
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_CAT), 32'h0000_0001);
    push_request(tcfo_pkg::FUNC_DEQ_DOG, 1'b0, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_CAT, 1'b1, 32'hDEAD_BEEF);
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_DOG), 32'h8000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_CAT, 1'b0, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'b0, 32'h0000_0000);
    // Typed pops take a class head regardless of age.
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_DOG), 32'h7FFF_FFFF);
    push_request(tcfo_pkg::FUNC_ENQ, 1'(tcfo_pkg::CLS_CAT), 32'hFFFF_FFFE);
    push_request(tcfo_pkg::FUNC_DEQ_CAT, 1'b0, 32'h0000_0000);
    push_request(tcfo_pkg::FUNC_DEQ_DOG, 1'b1, 32'h0000_0000);

    run_mixed(160);

    // Sender holds off until every result is out.
    hold_until_drained();

    // Churn: empty both queues, keep a few entries of each class in flight,
    // then alternate enqueue and dequeue-any. The first part of the churn
    // runs with no idling on either side.
    for (int unsigned i = 0; i < 2 * DEPTH + 1; i++) begin
      push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'($urandom_range(1)), $urandom());
    end
    for (int unsigned i = 0; i < 6; i++) begin
      push_request(tcfo_pkg::FUNC_ENQ, i[0], $urandom());
    end
    steady <= 1'b1;
    for (int unsigned i = 0; i < CHURN_PAIRS; i++) begin
      if (i == STEADY_PAIRS) steady <= 1'b0;
      push_request(tcfo_pkg::FUNC_ENQ, 1'($urandom_range(1)), $urandom());
      push_request(tcfo_pkg::FUNC_DEQ_ANY, 1'($urandom_range(1)), $urandom());
    end

    run_mixed(160);

    // Drain, then let the output register settle.
    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("two_class_fifo_oldest_any_tb passed");
    end else begin
      $display("two_class_fifo_oldest_any_tb failed");
    end
    $finish;
  end

endmodule
